// File: hw/rtl/line_segment_intersection_macros.svh
// Assertion macros used by the line intersection top-level RTL.
`ifndef LINE_SEGMENT_INTERSECTION_MACROS_SVH
`define LINE_SEGMENT_INTERSECTION_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define LSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define LSI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSI_ASSERT(lbl, prop, msg)
`define LSI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/lsi_pkg.sv
// Shared constants for the line intersection block.
`default_nettype none
package lsi_pkg;
  localparam int CW_DEF     = 16;
  localparam int FRAC_DEF   = 4;
  localparam int THR_W      = 33;
  localparam int RES_W      = 32;
  localparam int QW         = 32;
  localparam int OUT_FRAC   = 16;
  localparam int FIFO_DEPTH = 4;
endpackage
`default_nettype wire

// File: hw/rtl/lsi_if.sv
// Valid/ready channel interfaces for the input and result transactions.
`default_nettype none
interface lsi_in_if
  import lsi_pkg::*;
  #(parameter int COORD_WIDTH = CW_DEF) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_start_x;
  logic signed [COORD_WIDTH-1:0] a_start_y;
  logic signed [COORD_WIDTH-1:0] a_end_x;
  logic signed [COORD_WIDTH-1:0] a_end_y;
  logic signed [COORD_WIDTH-1:0] b_start_x;
  logic signed [COORD_WIDTH-1:0] b_start_y;
  logic signed [COORD_WIDTH-1:0] b_end_x;
  logic signed [COORD_WIDTH-1:0] b_end_y;
  modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, input ready);
  modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface lsi_out_if
  import lsi_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [RES_W-1:0] cross_x;
  logic signed [RES_W-1:0] cross_y;
  logic signed [RES_W-1:0] param_on_a;
  logic signed [RES_W-1:0] param_on_b;
  logic                    saturated;
  modport source (output valid, hit, cross_x, cross_y, param_on_a, param_on_b,
                  saturated, input ready);
  modport sink (input valid, hit, cross_x, cross_y, param_on_a, param_on_b,
                saturated, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/lsi_front.sv
// Front pipeline: differences, determinant, Cramer numerators and parallel test.
`default_nettype none
module lsi_front
  import lsi_pkg::*;
  #(
    parameter int COORD_WIDTH = CW_DEF,
    localparam int DIFW = COORD_WIDTH + 1,
    localparam int PRW  = 2 * DIFW,
    localparam int DENW = PRW + 1,
    localparam int MW   = DENW + DIFW,
    localparam int NXW  = MW + 1,
    localparam int EW   = 1 + 3 * DENW + 2 * NXW,
    localparam int TW   = (DENW > THR_W) ? DENW : THR_W
  ) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    lsi_in_if.sink                in_ch,
    input  wire logic [THR_W-1:0] thr,
    input  wire logic             fifo_full,
    output logic                  push_valid,
    output logic [EW-1:0]         push_data
  );

  logic [4:0] v_r;
  logic       en;

  logic signed [DIFW-1:0]        dax1_r, day1_r, dbx1_r, dby1_r, wx1_r, wy1_r;
  logic signed [COORD_WIDTH-1:0] asx1_r, asy1_r;
  logic signed [PRW-1:0]         p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  logic signed [DIFW-1:0]        dax2_r, day2_r;
  logic signed [COORD_WIDTH-1:0] asx2_r, asy2_r;
  logic signed [DENW-1:0]        den3_r, tnum3_r, unum3_r;
  logic signed [DIFW-1:0]        dax3_r, day3_r;
  logic signed [COORD_WIDTH-1:0] asx3_r, asy3_r;
  logic signed [MW-1:0]          m1_r, m2_r, m3_r, m4_r;
  logic signed [DENW-1:0]        den4_r, tnum4_r, unum4_r;
  logic signed [NXW-1:0]         nx5_r, ny5_r;
  logic signed [DENW-1:0]        den5_r, tnum5_r, unum5_r;
  logic                          hit5_r;
  logic [DENW-1:0]               denm;

  // The whole front advances unless its last stage is blocked by a full queue.
  assign en          = !v_r[4] || !fifo_full;
  assign in_ch.ready = en;
  assign push_valid  = v_r[4];
  assign push_data   = {hit5_r, den5_r, tnum5_r, unum5_r, nx5_r, ny5_r};

  // Valid bits of the five stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_ch.valid};
    end
  end

  // Determinant magnitude for the parallel test.
  assign denm = den4_r[DENW-1] ? DENW'(-den4_r) : DENW'(den4_r);

  // Datapath stages.
  always_ff @(posedge clk) begin
    if (en) begin
      dax1_r <= DIFW'(in_ch.a_end_x) - DIFW'(in_ch.a_start_x);
      day1_r <= DIFW'(in_ch.a_end_y) - DIFW'(in_ch.a_start_y);
      dbx1_r <= DIFW'(in_ch.b_end_x) - DIFW'(in_ch.b_start_x);
      dby1_r <= DIFW'(in_ch.b_end_y) - DIFW'(in_ch.b_start_y);
      wx1_r  <= DIFW'(in_ch.b_start_x) - DIFW'(in_ch.a_start_x);
      wy1_r  <= DIFW'(in_ch.b_start_y) - DIFW'(in_ch.a_start_y);
      asx1_r <= in_ch.a_start_x;
      asy1_r <= in_ch.a_start_y;

      p1_r   <= PRW'(dax1_r) * PRW'(dby1_r);
      p2_r   <= PRW'(day1_r) * PRW'(dbx1_r);
      p3_r   <= PRW'(wx1_r) * PRW'(dby1_r);
      p4_r   <= PRW'(wy1_r) * PRW'(dbx1_r);
      p5_r   <= PRW'(wx1_r) * PRW'(day1_r);
      p6_r   <= PRW'(wy1_r) * PRW'(dax1_r);
      dax2_r <= dax1_r;
      day2_r <= day1_r;
      asx2_r <= asx1_r;
      asy2_r <= asy1_r;

      den3_r  <= DENW'(p1_r) - DENW'(p2_r);
      tnum3_r <= DENW'(p3_r) - DENW'(p4_r);
      unum3_r <= DENW'(p5_r) - DENW'(p6_r);
      dax3_r  <= dax2_r;
      day3_r  <= day2_r;
      asx3_r  <= asx2_r;
      asy3_r  <= asy2_r;

      m1_r    <= MW'(asx3_r) * MW'(den3_r);
      m2_r    <= MW'(tnum3_r) * MW'(dax3_r);
      m3_r    <= MW'(asy3_r) * MW'(den3_r);
      m4_r    <= MW'(tnum3_r) * MW'(day3_r);
      den4_r  <= den3_r;
      tnum4_r <= tnum3_r;
      unum4_r <= unum3_r;

      nx5_r   <= NXW'(m1_r) + NXW'(m2_r);
      ny5_r   <= NXW'(m3_r) + NXW'(m4_r);
      den5_r  <= den4_r;
      tnum5_r <= tnum4_r;
      unum5_r <= unum4_r;
      hit5_r  <= TW'(denm) > TW'(thr);
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lsi_fifo.sv
// Short queue between the front and back pipelines.
`default_nettype none
module lsi_fifo
  import lsi_pkg::*;
  #(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW = $clog2(DEPTH + 1)
  ) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output logic [WIDTH-1:0]      head
  );

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, rptr_r;
  logic [CNTW-1:0]  cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push_valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lsi_div.sv
// Pipelined restoring divider, one quotient bit per stage, clipped to the signed range.
`default_nettype none
module lsi_div
  import lsi_pkg::*;
  #(
    parameter int WW  = 72,
    parameter int DMW = 36
  ) (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic [WW-1:0]  n_in,
    input  wire logic [DMW-1:0] d_in,
    input  wire logic           neg_in,
    output logic [RES_W-1:0]    q_out,
    output logic                sat_out
  );

  logic [WW-1:0]  rem_r [QW+1];
  logic [DMW-1:0] dd_r  [QW+1];
  logic [QW-1:0]  qb_r  [QW+1];
  logic           ng_r  [QW+1];
  logic           ov_r  [QW+1];
  logic [QW-1:0]  lim;
  logic [QW-1:0]  val;

  // Entry stage: a quotient of 2^QW or more cannot be represented.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= n_in;
      dd_r[0]  <= d_in;
      qb_r[0]  <= '0;
      ng_r[0]  <= neg_in;
      ov_r[0]  <= n_in >= (WW'(d_in) << QW);
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int B = QW - k;
    logic [WW-1:0] dsh;
    assign dsh = WW'(dd_r[k-1]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_r[k-1] >= dsh) begin
          rem_r[k] <= rem_r[k-1] - dsh;
          qb_r[k]  <= qb_r[k-1] | (QW'(1) << B);
        end else begin
          rem_r[k] <= rem_r[k-1];
          qb_r[k]  <= qb_r[k-1];
        end
        dd_r[k] <= dd_r[k-1];
        ng_r[k] <= ng_r[k-1];
        ov_r[k] <= ov_r[k-1];
      end
    end
  end

  // Clip the magnitude to the signed range and apply the sign.
  assign lim     = ng_r[QW] ? (QW'(1) << (QW - 1)) : ((QW'(1) << (QW - 1)) - 1'b1);
  assign sat_out = ov_r[QW] || (qb_r[QW] > lim);
  assign val     = sat_out ? lim : qb_r[QW];
  assign q_out   = RES_W'(ng_r[QW] ? -val : val);

endmodule
`default_nettype wire

// File: hw/rtl/lsi_back.sv
// Back pipeline: operand preparation, four dividers and the output register.
`default_nettype none
module lsi_back
  import lsi_pkg::*;
  #(
    parameter int COORD_WIDTH = CW_DEF,
    parameter int COORD_FRAC_BITS = FRAC_DEF,
    localparam int DIFW = COORD_WIDTH + 1,
    localparam int DENW = 2 * DIFW + 1,
    localparam int NXW  = DENW + DIFW + 1,
    localparam int EW   = 1 + 3 * DENW + 2 * NXW,
    localparam int PS   = OUT_FRAC - COORD_FRAC_BITS,
    localparam int NW   = NXW + OUT_FRAC + 2,
    localparam int DMW  = DENW + 1,
    localparam int WW   = (NW > DMW + QW) ? NW : DMW + QW,
    localparam int DL   = QW + 1
  ) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fifo_empty,
    input  wire logic [EW-1:0] head,
    output logic               pop,
    lsi_out_if.source          out_ch
  );

  logic                   en;
  logic                   h_hit;
  logic signed [DENW-1:0] h_den, h_tnum, h_unum;
  logic signed [NXW-1:0]  h_nx, h_ny;
  logic [DENW-1:0]        denm, tm, um;
  logic [NXW-1:0]         nxm, nym;

  logic                   pv_r, ph_r;
  logic [WW-1:0]          n_r [4];
  logic                   neg_r [4];
  logic [DMW-1:0]         d2_r;
  logic [DL-1:0]          dv_r, dh_r;
  logic [RES_W-1:0]       q [4];
  logic [3:0]             sat;

  // Everything moves when the output register is free or being drained.
  assign en  = !out_ch.valid || out_ch.ready;
  assign pop = en && !fifo_empty;

  assign {h_hit, h_den, h_tnum, h_unum, h_nx, h_ny} = head;

  // Magnitudes of the numerators and of the determinant.
  assign denm = h_den[DENW-1]  ? DENW'(-h_den)  : DENW'(h_den);
  assign tm   = h_tnum[DENW-1] ? DENW'(-h_tnum) : DENW'(h_tnum);
  assign um   = h_unum[DENW-1] ? DENW'(-h_unum) : DENW'(h_unum);
  assign nxm  = h_nx[NXW-1]    ? NXW'(-h_nx)    : NXW'(h_nx);
  assign nym  = h_ny[NXW-1]    ? NXW'(-h_ny)    : NXW'(h_ny);

  // Control of the preparation stage and the divider pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r         <= 1'b0;
      dv_r         <= '0;
      out_ch.valid <= 1'b0;
    end else if (en) begin
      pv_r         <= pop;
      dv_r         <= {dv_r[DL-2:0], pv_r};
      out_ch.valid <= dv_r[DL-1];
    end
  end

  // Rounding numerators 2|n| + |d| over divisor 2|d|.
  always_ff @(posedge clk) begin
    if (en) begin
      ph_r     <= h_hit;
      n_r[0]   <= (WW'(nxm) << (PS + 1)) + WW'(denm);
      n_r[1]   <= (WW'(nym) << (PS + 1)) + WW'(denm);
      n_r[2]   <= (WW'(tm) << (OUT_FRAC + 1)) + WW'(denm);
      n_r[3]   <= (WW'(um) << (OUT_FRAC + 1)) + WW'(denm);
      neg_r[0] <= h_nx[NXW-1] ^ h_den[DENW-1];
      neg_r[1] <= h_ny[NXW-1] ^ h_den[DENW-1];
      neg_r[2] <= h_tnum[DENW-1] ^ h_den[DENW-1];
      neg_r[3] <= h_unum[DENW-1] ^ h_den[DENW-1];
      d2_r     <= {denm, 1'b0};
      dh_r     <= {dh_r[DL-2:0], ph_r};
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    lsi_div #(.WW(WW), .DMW(DMW)) u_div (
      .clk     (clk),
      .en      (en),
      .n_in    (n_r[i]),
      .d_in    (d2_r),
      .neg_in  (neg_r[i]),
      .q_out   (q[i]),
      .sat_out (sat[i])
    );
  end

  // Output register; a parallel pair gives a miss with all fields zero.
  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.hit        <= dh_r[DL-1];
      out_ch.cross_x    <= dh_r[DL-1] ? q[0] : '0;
      out_ch.cross_y    <= dh_r[DL-1] ? q[1] : '0;
      out_ch.param_on_a <= dh_r[DL-1] ? q[2] : '0;
      out_ch.param_on_b <= dh_r[DL-1] ? q[3] : '0;
      out_ch.saturated  <= dh_r[DL-1] && (|sat);
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/line_segment_intersection.sv
// Throughput: one transaction per cycle unless the result channel stalls, set by the fully
// pipelined front and the four 32-stage bit-per-stage dividers in the back; a 4-entry
// queue sits between them.
// Reset (rst_n, synchronous, active low) empties all pipelines and the queue and
// clears the parallel threshold to zero.
`default_nettype none
`include "line_segment_intersection_macros.svh"
module line_segment_intersection
  import lsi_pkg::*;
  #(
    parameter int COORD_WIDTH = CW_DEF,
    parameter int COORD_FRAC_BITS = FRAC_DEF,
    localparam int DIFW = COORD_WIDTH + 1,
    localparam int DENW = 2 * DIFW + 1,
    localparam int NXW  = DENW + DIFW + 1,
    localparam int EW   = 1 + 3 * DENW + 2 * NXW
  ) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [THR_W-1:0] cfg_wr_data,
    lsi_in_if.sink                in_ch,
    lsi_out_if.source             out_ch
  );

  logic [THR_W-1:0] thr_r;
  logic             push_valid, fifo_full, fifo_empty, pop;
  logic [EW-1:0]    push_data, head;

  // Parallel threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  lsi_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .thr        (thr_r),
    .fifo_full  (fifo_full),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  lsi_fifo #(.WIDTH(EW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (fifo_full),
    .pop        (pop),
    .empty      (fifo_empty),
    .head       (head)
  );

  lsi_back #(.COORD_WIDTH(COORD_WIDTH), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  // A reset leaves no result transaction pending.
  `LSI_ASSERT_ALWAYS(a_rst_no_out, !rst_n |=> !out_ch.valid, "result valid after reset")
  // A miss carries only zero fields.
  `LSI_ASSERT(a_miss_zero, out_ch.valid && !out_ch.hit |-> out_ch.cross_x == 0 && out_ch.cross_y == 0 && out_ch.param_on_a == 0 && out_ch.param_on_b == 0 && !out_ch.saturated, "miss with nonzero fields")
  // The queue never accepts while full and never pops while empty.
  `LSI_ASSERT(a_queue_flow, (pop |-> !fifo_empty) and (fifo_full && push_valid |-> !in_ch.ready), "queue flow control broken")

endmodule
`default_nettype wire

// File: sim/line_segment_intersection_tb.sv
// Self-checking testbench for the line intersection block, with a predictor and random traffic.
`timescale 1ns / 1ps
module line_segment_intersection_tb
  import lsi_pkg::*;
  ();

  typedef struct packed {
    logic signed [CW_DEF-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
  } line_pair_t;

  typedef struct packed {
    logic                    hit;
    logic signed [RES_W-1:0] cross_x;
    logic signed [RES_W-1:0] cross_y;
    logic signed [RES_W-1:0] param_on_a;
    logic signed [RES_W-1:0] param_on_b;
    logic                    saturated;
  } crossing_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int RANDOM_ITEMS   = 450;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [THR_W-1:0] cfg_wr_data;

  lsi_in_if  #(.COORD_WIDTH(CW_DEF)) in_ch ();
  lsi_out_if out_ch ();

  line_segment_intersection u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Testbench copy of the parallel threshold and the results still owed.
  logic [THR_W-1:0] threshold;
  crossing_t        pending_crossings[$];
  int               send_idle_pct;
  int               recv_stall_pct;
  bit               hold_request;
  int               hold_left;
  bit               failed;
  int               quiet_cycles;

  // Clock with a 12 ns period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Rounded quotient n/d with ties away from zero; bit 32 flags clipping.
  function automatic logic [32:0] rounded_quotient(input logic signed [127:0] n,
                                                   input logic signed [127:0] d);
    logic [127:0] nm, dm, q, lim;
    logic         neg;
    logic         clip;
    nm   = n < 0 ? -n : n;
    dm   = d < 0 ? -d : d;
    neg  = (n < 0) != (d < 0);
    q    = (2 * nm + dm) / (2 * dm);
    lim  = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    clip = q > lim;
    if (clip) begin
      q = lim;
    end
    return {clip, neg ? -q[31:0] : q[31:0]};
  endfunction

  // Intersection of two lines by Cramer's rule, in exact wide arithmetic.
  function automatic crossing_t intersect_lines(input line_pair_t p, input logic [THR_W-1:0] thr);
    logic signed [127:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
    logic signed [127:0] dax, day, dbx, dby, wx, wy, den, tnum, unum, nx, ny, mag;
    logic [32:0]         qx, qy, qa, qb;
    crossing_t           r;
    asx = p.asx; asy = p.asy; aex = p.aex; aey = p.aey;
    bsx = p.bsx; bsy = p.bsy; bex = p.bex; bey = p.bey;
    dax = aex - asx; day = aey - asy;
    dbx = bex - bsx; dby = bey - bsy;
    wx  = bsx - asx; wy  = bsy - asy;
    den = dax * dby - day * dbx;
    r   = '0;
    mag = den < 0 ? -den : den;
    if (mag <= $signed({95'b0, thr})) begin
      return r;
    end
    tnum = wx * dby - wy * dbx;
    unum = wx * day - wy * dax;
    nx   = asx * den + tnum * dax;
    ny   = asy * den + tnum * day;
    qx   = rounded_quotient(nx <<< (OUT_FRAC - FRAC_DEF), den);
    qy   = rounded_quotient(ny <<< (OUT_FRAC - FRAC_DEF), den);
    qa   = rounded_quotient(tnum <<< OUT_FRAC, den);
    qb   = rounded_quotient(unum <<< OUT_FRAC, den);
    r.hit        = 1'b1;
    r.cross_x    = qx[31:0];
    r.cross_y    = qy[31:0];
    r.param_on_a = qa[31:0];
    r.param_on_b = qb[31:0];
    r.saturated  = qx[32] | qy[32] | qa[32] | qb[32];
    return r;
  endfunction

  // Offer one line pair, after a random gap, and record its expected result.
  task automatic send_pair(input line_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.a_start_x <= p.asx;
    in_ch.a_start_y <= p.asy;
    in_ch.a_end_x   <= p.aex;
    in_ch.a_end_y   <= p.aey;
    in_ch.b_start_x <= p.bsx;
    in_ch.b_start_y <= p.bsy;
    in_ch.b_end_x   <= p.bex;
    in_ch.b_end_y   <= p.bey;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    pending_crossings.push_back(intersect_lines(p, threshold));
  endtask

  task automatic send_coords(input int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
    line_pair_t p;
    p = '{ax0[15:0], ay0[15:0], ax1[15:0], ay1[15:0],
          bx0[15:0], by0[15:0], bx1[15:0], by1[15:0]};
    send_pair(p);
  endtask

  // Let the pipeline empty, then write the threshold.
  task automatic set_threshold(input logic [THR_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_crossings.size() != 0) begin
      @(posedge clk);
    end
    repeat (45) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    threshold = value;
  endtask

  // Random line pair: full range, small coordinates, or nearly parallel.
  function automatic line_pair_t random_pair();
    line_pair_t p;
    int         sel, dx, dy, span;
    sel  = $urandom_range(9);
    span = $urandom_range(1) ? 64 : 2048;
    p = {$urandom, $urandom, $urandom, $urandom};
    if (sel < 4) begin
      return p;
    end
    p.asx = 16'($urandom_range(2 * span) - span);
    p.asy = 16'($urandom_range(2 * span) - span);
    p.aex = 16'($urandom_range(2 * span) - span);
    p.aey = 16'($urandom_range(2 * span) - span);
    p.bsx = 16'($urandom_range(2 * span) - span);
    p.bsy = 16'($urandom_range(2 * span) - span);
    if (sel < 8) begin
      p.bex = 16'($urandom_range(2 * span) - span);
      p.bey = 16'($urandom_range(2 * span) - span);
    end else begin
      dx = int'(p.aex) - int'(p.asx) + int'($urandom_range(2)) - 1;
      dy = int'(p.aey) - int'(p.asy) + int'($urandom_range(2)) - 1;
      p.bex = p.bsx + dx[15:0];
      p.bey = p.bsy + dy[15:0];
    end
    return p;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_pair(random_pair());
  endtask

  // Extremes, axis crossings, parallel, coincident, zero-length and clipped cases.
  task automatic test_directed();
    set_threshold('0);
    send_coords(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_coords(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
    send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_coords(0, 0, 16, 0, 8, -16, 8, 16);
    send_coords(0, 0, 16, 16, 0, 16, 16, 0);
    send_coords(0, 0, 16, 0, 0, 16, 16, 16);
    send_coords(0, 0, 16, 16, 32, 32, 48, 48);
    send_coords(5, 7, 5, 7, 0, 0, 16, 3);
    send_coords(0, 0, 16, 0, 0, 0, 0, 0);
    send_coords(0, 0, 32767, 1, 0, 16, 32767, 17 + 1);
    send_coords(-32768, 0, 32767, 1, 32767, -32768, -32768, 32767);
    send_coords(0, 0, 1, 0, 32767, 32767, 32767, -32768);
    send_coords(0, 0, 3, 1, 0, 1, 3, 0);
    send_coords(1, 1, -2, 2, 3, -1, 3, 1);
    send_coords(0, 0, 1, 1, 0, 0, 2, 1);
    set_threshold(33'd1);
    send_coords(0, 0, 1, 1, 0, 0, 2, 1);
    send_coords(0, 0, 2, 1, 0, 0, 1, 2);
    set_threshold({THR_W{1'b1}});
    send_coords(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
    send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
  endtask

  task automatic test_no_idling();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_threshold('0);
    run_random(RANDOM_ITEMS);
  endtask

  task automatic test_sender_idle();
    send_idle_pct = 49;
    recv_stall_pct = 0;
    set_threshold(33'd256);
    run_random(RANDOM_ITEMS);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct = 0;
    recv_stall_pct = 49;
    set_threshold(33'd3);
    run_random(RANDOM_ITEMS);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 38;
    recv_stall_pct = 38;
    set_threshold({1'b0, $urandom} >> $urandom_range(31));
    run_random(RANDOM_ITEMS);
  endtask

  // Long receiver hold-off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_threshold('0);
    hold_request = 1'b1;
    run_random(80);
  endtask

  // Result ready: random stalls, plus the long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each result transaction with the oldest expectation; watchdog.
  always @(posedge clk) begin
    crossing_t want;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_crossings.size() == 0) begin
          $display("%0t: result with none expected", $time);
          failed = 1'b1;
        end else begin
          want = pending_crossings.pop_front();
          if (out_ch.hit !== want.hit) begin
            $display("%0t: hit expected %b actual %b", $time, want.hit, out_ch.hit);
            failed = 1'b1;
          end
          if (out_ch.cross_x !== want.cross_x) begin
            $display("%0t: cross_x expected %h actual %h", $time, want.cross_x,
                     out_ch.cross_x);
            failed = 1'b1;
          end
          if (out_ch.cross_y !== want.cross_y) begin
            $display("%0t: cross_y expected %h actual %h", $time, want.cross_y,
                     out_ch.cross_y);
            failed = 1'b1;
          end
          if (out_ch.param_on_a !== want.param_on_a) begin
            $display("%0t: param_on_a expected %h actual %h", $time, want.param_on_a,
                     out_ch.param_on_a);
            failed = 1'b1;
          end
          if (out_ch.param_on_b !== want.param_on_b) begin
            $display("%0t: param_on_b expected %h actual %h", $time, want.param_on_b,
                     out_ch.param_on_b);
            failed = 1'b1;
          end
          if (out_ch.saturated !== want.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                     out_ch.saturated);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Reset, run the tests in turn, drain and report.
  initial begin
    failed = 1'b0;
    quiet_cycles = 0;
    hold_request = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    threshold = '0;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.a_start_x <= '0;
    in_ch.a_start_y <= '0;
    in_ch.a_end_x <= '0;
    in_ch.a_end_y <= '0;
    in_ch.b_start_x <= '0;
    in_ch.b_start_y <= '0;
    in_ch.b_end_x <= '0;
    in_ch.b_end_y <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    in_ch.valid <= 1'b0;
    while (pending_crossings.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
